// ----- hdl/awsc_pkg.sv -----
// types and constants shared by the ack window sender control block
// no dependencies
package awsc_pkg;

   localparam int WIN_W      = 7;
   localparam int ID_W       = 16;
   localparam int MODE_W     = 2;
   localparam int KIND_W     = 2;
   localparam int SLOT_COUNT = 64;
   localparam int SLOT_IDX_W = 6;

   localparam logic [MODE_W-1:0] MODE_DATA    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EOF     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ACK     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd3;

   localparam logic [KIND_W-1:0] KIND_XMIT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ROUND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

   // burst: walk the slots and transmit the unacked ones; else one result word
   typedef struct packed {
      logic                  burst;
      logic [KIND_W-1:0]     kind;
      logic [ID_W-1:0]       base;
      logic [WIN_W-1:0]      window;
      logic                  lost;
      logic [WIN_W-1:0]      count;
      logic [SLOT_COUNT-1:0] marks;
   } cmd_type;

endpackage

// ----- hdl/awsc_front.sv -----
// front end: accepts events, keeps the round state and ack marks, issues commands
// depends on awsc_pkg
module awsc_front #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [awsc_pkg::MODE_W-1:0] req_mode,
   input  logic [awsc_pkg::ID_W-1:0]   req_ack_id,
   output awsc_pkg::cmd_type            cmd,
   output logic                         cmd_push,
   input  logic                         cmd_full
);
   import awsc_pkg::*;

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [WIN_W:0] MAX_WIN = (WIN_W+1)'(MAX_WINDOW);

   logic [WIN_W-1:0]      window_ff, window_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;
   logic [ID_W-1:0]       base_ff, base_in;
   logic [WIN_W-1:0]      filled_ff, filled_in;
   logic [MAX_WINDOW-1:0] marks_ff, marks_in;
   logic [WIN_W-1:0]      acks_ff, acks_in;
   logic                  loss_ff, loss_in;
   logic                  closing_ff, closing_in;

   logic                  accept;
   logic                  sending;
   logic [WIN_W-1:0]      fill_next;
   logic [WIN_W-1:0]      acks_next;
   logic [ID_W-1:0]       off;
   logic                  off_hit;
   logic                  mark_at;
   logic [WIN_W:0]        dbl;
   logic [WIN_W-1:0]      win_grow;
   logic [WIN_W-1:0]      win_new;

   assign full      = cmd_full;
   assign accept    = push & ~cmd_full;
   assign sending   = (filled_ff == window_ff);
   assign fill_next = filled_ff + 1'b1;
   assign acks_next = acks_ff + 1'b1;
   assign off       = req_ack_id - base_ff;
   assign off_hit   = (off < {{(ID_W-WIN_W){1'b0}}, window_ff});
   assign mark_at   = off_hit ? marks_ff[off[IDX_W-1:0]] : 1'b1;
   assign dbl       = {window_ff, 1'b0};
   assign win_grow  = (dbl > MAX_WIN) ? MAX_WIN[WIN_W-1:0] : dbl[WIN_W-1:0];

   always_comb begin
      window_in  = window_ff;
      next_id_in = next_id_ff;
      base_in    = base_ff;
      filled_in  = filled_ff;
      marks_in   = marks_ff;
      acks_in    = acks_ff;
      loss_in    = loss_ff;
      closing_in = closing_ff;
      cmd_push   = 1'b0;
      cmd        = '0;
      win_new    = window_ff;
      if (accept) begin
         case (req_mode)
            MODE_DATA, MODE_EOF: begin
               if (!sending) begin
                  filled_in  = fill_next;
                  next_id_in = next_id_ff + 1'b1;
                  if (req_mode == MODE_EOF) begin
                     closing_in = 1'b1;
                     win_new    = fill_next;
                     window_in  = fill_next;
                  end
                  if (fill_next == win_new) begin
                     cmd_push     = 1'b1;
                     cmd.burst    = 1'b1;
                     cmd.kind     = KIND_XMIT;
                     cmd.base     = base_ff;
                     cmd.window   = win_new;
                     cmd.lost     = loss_ff;
                     cmd.count    = win_new - acks_ff;
                     cmd.marks    = SLOT_COUNT'(marks_ff);
                  end
               end
            end
            MODE_ACK: begin
               if (sending && off_hit && !mark_at) begin
                  marks_in[off[IDX_W-1:0]] = 1'b1;
                  acks_in = acks_next;
                  if (acks_next == window_ff) begin
                     cmd_push  = 1'b1;
                     cmd.burst = 1'b0;
                     filled_in = '0;
                     marks_in  = '0;
                     acks_in   = '0;
                     loss_in   = 1'b0;
                     if (closing_ff) begin
                        window_in  = WIN_W'(1);
                        next_id_in = '0;
                        base_in    = '0;
                        closing_in = 1'b0;
                        cmd.kind   = KIND_DONE;
                        cmd.window = WIN_W'(1);
                        cmd.lost   = 1'b0;
                     end else begin
                        if (loss_ff) begin
                           win_new = WIN_W'(1);
                        end else if ({1'b0, window_ff} < MAX_WIN) begin
                           win_new = win_grow;
                        end
                        window_in  = win_new;
                        base_in    = next_id_ff;
                        cmd.kind   = KIND_ROUND;
                        cmd.window = win_new;
                        cmd.lost   = loss_ff;
                     end
                  end
               end
            end
            MODE_TIMEOUT: begin
               if (sending) begin
                  loss_in    = 1'b1;
                  cmd_push   = 1'b1;
                  cmd.burst  = 1'b1;
                  cmd.kind   = KIND_XMIT;
                  cmd.base   = base_ff;
                  cmd.window = window_ff;
                  cmd.lost   = 1'b1;
                  cmd.count  = window_ff - acks_ff;
                  cmd.marks  = SLOT_COUNT'(marks_ff);
               end
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WIN_W'(1);
         next_id_ff <= '0;
         base_ff    <= '0;
         filled_ff  <= '0;
         marks_ff   <= '0;
         acks_ff    <= '0;
         loss_ff    <= 1'b0;
         closing_ff <= 1'b0;
      end else begin
         window_ff  <= window_in;
         next_id_ff <= next_id_in;
         base_ff    <= base_in;
         filled_ff  <= filled_in;
         marks_ff   <= marks_in;
         acks_ff    <= acks_in;
         loss_ff    <= loss_in;
         closing_ff <= closing_in;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (filled_ff <= window_ff) && (acks_ff <= window_ff))
      else $error("fill or ack count above window");
   a_win_range: assert property (@(posedge clock) disable iff (reset)
      (window_ff != '0) && ({1'b0, window_ff} <= MAX_WIN))
      else $error("window out of range");
   a_round_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_ACK) && cmd_push) |=> (acks_ff == '0) && (filled_ff == '0))
      else $error("round state not cleared after completion");
`endif

endmodule

// ----- hdl/awsc_cmd_queue.sv -----
// two-entry command queue between front end and back end
// depends on awsc_pkg
module awsc_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  awsc_pkg::cmd_type wr_cmd,
   input  logic              wr_push,
   output logic              wr_full,
   output awsc_pkg::cmd_type rd_cmd,
   output logic              rd_valid,
   input  logic              rd_pop
);
   import awsc_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr;
   logic       do_rd;

   assign wr_full  = (cnt_ff == 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_cmd   = q_ff[rd_ptr_ff];
   assign do_wr    = wr_push & ~wr_full;
   assign do_rd    = rd_pop & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      cnt_in    = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- hdl/awsc_back.sv -----
// back end: walks window slots for transmit bursts and drives the result register
// depends on awsc_pkg
module awsc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  awsc_pkg::cmd_type            cmd,
   input  logic                         cmd_valid,
   output logic                         cmd_pop,
   output logic                         empty,
   input  logic                         pop,
   output logic [awsc_pkg::KIND_W-1:0] rsp_kind,
   output logic [awsc_pkg::ID_W-1:0]   rsp_packet_id,
   output logic [awsc_pkg::WIN_W-1:0]  rsp_window_size,
   output logic                         rsp_lost,
   output logic                         rsp_last
);
   import awsc_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BURST = 1'b1;

   logic                  state_ff, state_in;
   logic [ID_W-1:0]       base_ff, base_in;
   logic [WIN_W-1:0]      win_ff, win_in;
   logic                  lost_ff, lost_in;
   logic [WIN_W-1:0]      count_ff, count_in;
   logic [SLOT_COUNT-1:0] marks_ff, marks_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [WIN_W-1:0]      wsize_ff, wsize_in;
   logic                  rlost_ff, rlost_in;
   logic                  last_ff, last_in;
   logic                  rsp_load;
   logic                  out_free;

   assign out_free        = ~rsp_valid_ff | pop;
   assign empty           = ~rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_packet_id   = id_ff;
   assign rsp_window_size = wsize_ff;
   assign rsp_lost        = rlost_ff;
   assign rsp_last        = last_ff;

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      win_in   = win_ff;
      lost_in  = lost_ff;
      count_in = count_ff;
      marks_in = marks_ff;
      slot_in  = slot_ff;
      kind_in  = kind_ff;
      id_in    = id_ff;
      wsize_in = wsize_ff;
      rlost_in = rlost_ff;
      last_in  = last_ff;
      rsp_load = 1'b0;
      cmd_pop  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.burst) begin
                  cmd_pop  = 1'b1;
                  base_in  = cmd.base;
                  win_in   = cmd.window;
                  lost_in  = cmd.lost;
                  count_in = cmd.count;
                  marks_in = cmd.marks;
                  slot_in  = '0;
                  state_in = ST_BURST;
               end else if (out_free) begin
                  cmd_pop  = 1'b1;
                  rsp_load = 1'b1;
                  kind_in  = cmd.kind;
                  id_in    = '0;
                  wsize_in = cmd.window;
                  rlost_in = cmd.lost;
                  last_in  = 1'b1;
               end
            end
         end
         ST_BURST: begin
            if (marks_ff[slot_ff]) begin
               slot_in = slot_ff + 1'b1;
            end else if (out_free) begin
               rsp_load = 1'b1;
               kind_in  = KIND_XMIT;
               id_in    = base_ff + {{(ID_W-SLOT_IDX_W){1'b0}}, slot_ff};
               wsize_in = win_ff;
               rlost_in = lost_ff;
               last_in  = (count_ff == WIN_W'(1));
               count_in = count_ff - 1'b1;
               slot_in  = slot_ff + 1'b1;
               if (count_ff == WIN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      win_ff   <= win_in;
      lost_ff  <= lost_in;
      marks_ff <= marks_in;
      slot_ff  <= slot_in;
      kind_ff  <= kind_in;
      id_ff    <= id_in;
      wsize_ff <= wsize_in;
      rlost_ff <= rlost_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_burst_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BURST) |-> (count_ff != '0))
      else $error("burst running with nothing left to send");
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_in && (state_ff == ST_BURST)) |=> (state_ff == ST_IDLE))
      else $error("burst did not end on its last word");
`endif

endmodule

// ----- hdl/ack_window_sender_control_top.sv -----
// path: a round or done word goes through the command queue, then the result register; the
//   first word of a transmit burst through the queue, the burst registers and the slot walk
// throughput: one event a cycle while the two-entry command queue has room; a transmit
//   burst is loaded, then walks at most 64 window slots, held while the result word waits
// reset: synchronous, active high; window 1, ids and counts 0, ack marks cleared at once
// top level: front end, command queue, back end; depends on awsc_pkg
module ack_window_sender_control_top #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [awsc_pkg::MODE_W-1:0] req_mode,
   input  logic [awsc_pkg::ID_W-1:0]   req_ack_id,
   output logic                         empty,
   input  logic                         pop,
   output logic [awsc_pkg::KIND_W-1:0] rsp_kind,
   output logic [awsc_pkg::ID_W-1:0]   rsp_packet_id,
   output logic [awsc_pkg::WIN_W-1:0]  rsp_window_size,
   output logic                         rsp_lost,
   output logic                         rsp_last
);
   import awsc_pkg::*;

   cmd_type wr_cmd;
   logic    wr_push;
   logic    wr_full;
   cmd_type rd_cmd;
   logic    rd_valid;
   logic    rd_pop;

   awsc_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_mode   (req_mode),
      .req_ack_id (req_ack_id),
      .cmd        (wr_cmd),
      .cmd_push   (wr_push),
      .cmd_full   (wr_full)
   );

   awsc_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_cmd   (wr_cmd),
      .wr_push  (wr_push),
      .wr_full  (wr_full),
      .rd_cmd   (rd_cmd),
      .rd_valid (rd_valid),
      .rd_pop   (rd_pop)
   );

   awsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd             (rd_cmd),
      .cmd_valid       (rd_valid),
      .cmd_pop         (rd_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_packet_id   (rsp_packet_id),
      .rsp_window_size (rsp_window_size),
      .rsp_lost        (rsp_lost),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- tb/sv/ack_window_sender_control_top_tb.sv -----
// testbench for ack_window_sender_control_top: a directed event table, then random
// transfers, with every result word checked against an in-bench window predictor
// depends on awsc_pkg and the ack_window_sender_control_top rtl
module ack_window_sender_control_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import awsc_pkg::*;

   localparam int MAX_WINDOW   = 64;
   localparam int RAND_ITEMS   = 80;
   localparam int CLEAN_FROM   = 50;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 120;
   localparam int LIMIT_CYCLES = 1000000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   packet_id;
      logic [WIN_W-1:0]  window_size;
      logic              lost;
      logic              last;
   } rsp_word_type;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   ack_id;
      bit                chk;
      int                n;
      rsp_word_type      first;
   } dir_row_type;

   localparam rsp_word_type NO_WORD = '0;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [MODE_W-1:0]   req_mode = MODE_DATA;
   logic [ID_W-1:0]     req_ack_id = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [ID_W-1:0]     rsp_packet_id;
   logic [WIN_W-1:0]    rsp_window_size;
   logic                rsp_lost;
   logic                rsp_last;

   // predicted sender window state
   logic [WIN_W-1:0]      win_now;
   logic [ID_W-1:0]       next_id;
   logic [ID_W-1:0]       base_id;
   logic [WIN_W-1:0]      filled;
   logic [WIN_W-1:0]      acked_cnt;
   logic [SLOT_COUNT-1:0] ack_marks;
   logic                  loss_seen;
   logic                  closing;

   rsp_word_type due_words[$];
   rsp_word_type step_words[$];
   dir_row_type  dir_rows[26];
   int           err_count = 0;
   int           cycle_cnt = 0;
   bit           stall_rsp = 1'b0;
   bit           rsp_stalled = 1'b0;
   bit           no_idle = 1'b0;

   ack_window_sender_control_top #(
      .MAX_WINDOW(MAX_WINDOW)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_ack_id      (req_ack_id),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_packet_id   (rsp_packet_id),
      .rsp_window_size (rsp_window_size),
      .rsp_lost        (rsp_lost),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void clear_window();
      win_now   = 7'd1;
      next_id   = '0;
      base_id   = '0;
      filled    = '0;
      acked_cnt = '0;
      ack_marks = '0;
      loss_seen = 1'b0;
      closing   = 1'b0;
   endfunction

   function automatic void add_word(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                    input logic l);
      rsp_word_type w;
      w.kind        = k;
      w.packet_id   = id;
      w.window_size = win_now;
      w.lost        = l;
      w.last        = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void resend_open_slots();
      for (int k = 0; k < int'(win_now) && k < SLOT_COUNT; k++) begin
         if (!ack_marks[k]) add_word(KIND_XMIT, base_id + k[ID_W-1:0], loss_seen);
      end
   endfunction

   // advances the window state by one event and leaves its words in step_words
   function automatic void step_sender(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id);
      logic [ID_W-1:0] off;
      logic            was_lost;
      int              grown;
      bit              sending;
      step_words.delete();
      sending = (filled == win_now);
      if (m == MODE_DATA || m == MODE_EOF) begin
         if (!sending) begin
            filled  = filled + 1'b1;
            next_id = next_id + 1'b1;
            if (m == MODE_EOF) begin
               closing = 1'b1;
               win_now = filled;
            end
            if (filled == win_now) resend_open_slots();
         end
      end else if (m == MODE_ACK) begin
         off = id - base_id;
         if (sending && off < win_now && off < SLOT_COUNT &&
             !ack_marks[off[SLOT_IDX_W-1:0]]) begin
            ack_marks[off[SLOT_IDX_W-1:0]] = 1'b1;
            acked_cnt = acked_cnt + 1'b1;
            if (acked_cnt == win_now) begin
               if (closing) begin
                  clear_window();
                  add_word(KIND_DONE, '0, 1'b0);
               end else begin
                  was_lost = loss_seen;
                  if (was_lost) begin
                     win_now = 7'd1;
                  end else begin
                     grown = 2 * int'(win_now);
                     if (grown > MAX_WINDOW) begin
                        grown = MAX_WINDOW;
                     end
                     win_now = grown[WIN_W-1:0];
                  end
                  base_id   = next_id;
                  filled    = '0;
                  acked_cnt = '0;
                  loss_seen = 1'b0;
                  ack_marks = '0;
                  add_word(KIND_ROUND, '0, was_lost);
               end
            end
         end
      end else if (sending) begin
         loss_seen = 1'b1;
         resend_open_slots();
      end
      if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
   endfunction

   // mostly well-formed events for the current phase, some noise
   function automatic void pick_event(input bit clean, output logic [MODE_W-1:0] m,
                                      output logic [ID_W-1:0] id, output bit useful);
      int r;
      int k;
      r      = $urandom_range(0, 99);
      id     = ID_W'($urandom_range(0, 65535));
      useful = 1'b1;
      if (filled != win_now) begin
         if (r < 5) begin
            m      = r[0] ? MODE_ACK : MODE_TIMEOUT;
            useful = 1'b0;
         end else if (!clean && r < 13) begin
            m = MODE_EOF;
         end else begin
            m = MODE_DATA;
         end
      end else if (r < 6) begin
         m      = r[0] ? MODE_DATA : MODE_EOF;
         useful = 1'b0;
      end else if (r < 10) begin
         m      = MODE_ACK;
         useful = 1'b0;
      end else if (!clean && r < 20) begin
         m = MODE_TIMEOUT;
      end else begin
         m = MODE_ACK;
         do k = $urandom_range(0, int'(win_now) - 1);
         while (ack_marks[k] && r >= 24);
         id = base_id + k[ID_W-1:0];
      end
   endfunction

   task automatic offer_word(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push       <= 1'b1;
      req_mode   <= m;
      req_ack_id <= id;
      @(posedge clock);
      while (full) @(posedge clock);
      step_sender(m, id);
      foreach (step_words[i]) due_words.push_back(step_words[i]);
   endtask

   function automatic void cmp_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         err_count++;
      end
   endfunction

   task automatic check_word();
      rsp_word_type exp_w;
      if (due_words.size() == 0) begin
         $error("unexpected result word: kind %0d packet_id %0d", rsp_kind, rsp_packet_id);
         err_count++;
      end else begin
         exp_w = due_words.pop_front();
         cmp_field("kind", exp_w.kind, rsp_kind);
         cmp_field("packet_id", exp_w.packet_id, rsp_packet_id);
         cmp_field("window_size", exp_w.window_size, rsp_window_size);
         cmp_field("lost", exp_w.lost, rsp_lost);
         cmp_field("last", exp_w.last, rsp_last);
      end
   endtask

   initial begin : rsp_side
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (stall_rsp && !rsp_stalled) begin
            gap         = HOLD_CYCLES;
            rsp_stalled = 1'b1;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         check_word();
      end
   end

   initial begin : watchdog
      while (cycle_cnt < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("ack_window_sender_control_top verification failed");
      $finish;
   end

   initial begin : stimulus
      int                useful_cnt;
      bit                useful;
      logic [MODE_W-1:0] m;
      logic [ID_W-1:0]   id;
      clear_window();
      dir_rows = '{
         '{MODE_ACK,     16'd0,    1'b1, 0, NO_WORD},
         '{MODE_TIMEOUT, 16'd0,    1'b1, 0, NO_WORD},
         '{MODE_DATA,    16'd0,    1'b1, 1, '{KIND_XMIT, 16'd0, 7'd1, 1'b0, 1'b1}},
         '{MODE_DATA,    16'd0,    1'b1, 0, NO_WORD},
         '{MODE_EOF,     16'd0,    1'b1, 0, NO_WORD},
         '{MODE_ACK,     16'hffff, 1'b1, 0, NO_WORD},
         '{MODE_TIMEOUT, 16'hffff, 1'b1, 1, '{KIND_XMIT, 16'd0, 7'd1, 1'b1, 1'b1}},
         '{MODE_ACK,     16'd0,    1'b1, 1, '{KIND_ROUND, 16'd0, 7'd1, 1'b1, 1'b1}},
         '{MODE_DATA,    16'hffff, 1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd1,    1'b0, 0, NO_WORD},
         '{MODE_DATA,    16'd0,    1'b0, 0, NO_WORD},
         '{MODE_DATA,    16'd0,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd3,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd3,    1'b0, 0, NO_WORD},
         '{MODE_TIMEOUT, 16'd0,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd2,    1'b0, 0, NO_WORD},
         '{MODE_DATA,    16'd0,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd4,    1'b0, 0, NO_WORD},
         '{MODE_DATA,    16'd0,    1'b0, 0, NO_WORD},
         '{MODE_DATA,    16'd0,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd6,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd5,    1'b0, 0, NO_WORD},
         '{MODE_DATA,    16'd0,    1'b0, 0, NO_WORD},
         '{MODE_EOF,     16'd0,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd8,    1'b0, 0, NO_WORD},
         '{MODE_ACK,     16'd7,    1'b1, 1, '{KIND_DONE, 16'd0, 7'd1, 1'b0, 1'b1}}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         offer_word(dir_rows[i].mode, dir_rows[i].ack_id);
         if (dir_rows[i].chk) begin
            if (step_words.size() != dir_rows[i].n) begin
               $error("row %0d word count: expected %0d, actual %0d", i, dir_rows[i].n,
                      step_words.size());
               err_count++;
            end else if (dir_rows[i].n > 0 && step_words[0] != dir_rows[i].first) begin
               $error("row %0d word: expected %h, actual %h", i, dir_rows[i].first,
                      step_words[0]);
               err_count++;
            end
         end
      end
      // mixed transfers, then clean rounds that let the window grow
      useful_cnt = 0;
      while (useful_cnt < RAND_ITEMS) begin
         no_idle = (useful_cnt >= 35 && useful_cnt < 50);
         if (useful_cnt == 20) stall_rsp = 1'b1;
         pick_event(useful_cnt >= CLEAN_FROM, m, id, useful);
         offer_word(m, id);
         if (useful) useful_cnt++;
      end
      no_idle = 1'b0;
      push <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("ack_window_sender_control_top verification clean");
      end else begin
         $display("ack_window_sender_control_top verification failed");
      end
      $finish;
   end

endmodule
